### src/iirdf2_pkg.sv
// Shared types, widths, register indexes and the control program for the
// direct form II IIR filter. No dependencies.
`timescale 1ns / 1ps

package iirdf2_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 18;
	localparam int FRAC_W    = 14;
	localparam int STATE_W   = 24;
	localparam int MAX_TAPS  = 3;
	localparam int PROD_W    = COEF_W + STATE_W;
	localparam int ACC_W     = PROD_W + 3;
	localparam int RND_W     = ACC_W - FRAC_W;
	localparam int NUM_FF    = MAX_TAPS + 1;
	localparam int NUM_FB    = MAX_TAPS;
	localparam int TAP_SEL_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int PC_W      = 3;
	localparam int PROG_LEN  = 5;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [STATE_W-1:0]  state_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic signed [RND_W-1:0]    rnd_t;
	typedef logic [PC_W-1:0]            pc_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

	localparam coef_t COEF_B0_RESET = coef_t'(16384);

	localparam cfg_idx_t REG_FF_COEF_0 = cfg_idx_t'(0);
	localparam cfg_idx_t REG_FF_COEF_1 = cfg_idx_t'(1);
	localparam cfg_idx_t REG_FF_COEF_2 = cfg_idx_t'(2);
	localparam cfg_idx_t REG_FF_COEF_3 = cfg_idx_t'(3);
	localparam cfg_idx_t REG_FB_COEF_1 = cfg_idx_t'(4);
	localparam cfg_idx_t REG_FB_COEF_2 = cfg_idx_t'(5);
	localparam cfg_idx_t REG_FB_COEF_3 = cfg_idx_t'(6);

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_MAC,
		OP_RND_W,
		OP_MAC_B0,
		OP_RND_Y
	} op_t;

	typedef enum logic [1:0] {
		COND_NONE,
		COND_WAIT_IN,
		COND_TAP_MORE,
		COND_WAIT_OUT
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ctrl_t;

	typedef struct packed {
		op_t  op;
		logic fire;
	} dp_ctrl_t;

	localparam pc_t PC_IDLE  = pc_t'(0);
	localparam pc_t PC_MAC   = pc_t'(1);
	localparam pc_t PC_RND_W = pc_t'(2);
	localparam pc_t PC_B0    = pc_t'(3);
	localparam pc_t PC_RND_Y = pc_t'(4);

	function automatic ctrl_t ucode(pc_t pc);
		ctrl_t c;
		case (pc)
			PC_IDLE:  c = '{op: OP_LOAD,   cond: COND_WAIT_IN,  target: PC_IDLE};
			PC_MAC:   c = '{op: OP_MAC,    cond: COND_TAP_MORE, target: PC_MAC};
			PC_RND_W: c = '{op: OP_RND_W,  cond: COND_NONE,     target: PC_IDLE};
			PC_B0:    c = '{op: OP_MAC_B0, cond: COND_NONE,     target: PC_IDLE};
			PC_RND_Y: c = '{op: OP_RND_Y,  cond: COND_WAIT_OUT, target: PC_RND_Y};
			default:  c = '{op: OP_NOP,    cond: COND_NONE,     target: PC_IDLE};
		endcase
		return c;
	endfunction

endpackage

### src/iirdf2_seq.sv
// Microcode sequencer: step counter, control ROM lookup, jump logic and tap
// counter. Depends on iirdf2_pkg.
`timescale 1ns / 1ps

module iirdf2_seq
	import iirdf2_pkg::*;
#(
	parameter int ORDER = 3,
	parameter int TAP_W = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             out_busy,
	output dp_ctrl_t         dp_ctrl,
	output logic [TAP_W-1:0] tap
);

	pc_t              pc_q;
	pc_t              pc_next;
	pc_t              pc_inc;
	logic [TAP_W-1:0] tap_q;
	ctrl_t            ctrl;
	logic             jump;
	logic             fire;
	logic             tap_last;

	assign ctrl     = ucode(pc_q);
	assign tap_last = (tap_q == TAP_W'(ORDER - 1));
	assign pc_inc   = (pc_q == pc_t'(PROG_LEN - 1)) ? PC_IDLE : pc_q + pc_t'(1);

	always_comb begin
		case (ctrl.cond)
			COND_WAIT_IN:  jump = !in_valid;
			COND_TAP_MORE: jump = !tap_last;
			COND_WAIT_OUT: jump = out_busy;
			default:       jump = 1'b0;
		endcase
	end

	always_comb begin
		case (ctrl.cond)
			COND_WAIT_IN:  fire = in_valid;
			COND_WAIT_OUT: fire = !out_busy;
			default:       fire = 1'b1;
		endcase
	end

	assign pc_next = jump ? ctrl.target : pc_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= PC_IDLE;
			tap_q <= '0;
		end else begin
			pc_q <= pc_next;
			if (ctrl.op == OP_LOAD && fire) begin
				tap_q <= '0;
			end else if (ctrl.op == OP_MAC && !tap_last) begin
				tap_q <= tap_q + TAP_W'(1);
			end
		end
	end

	assign dp_ctrl.op   = ctrl.op;
	assign dp_ctrl.fire = fire;
	assign tap          = tap_q;

`ifndef SYNTHESIS
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		tap_q <= TAP_W'(ORDER - 1))
		else $error("tap counter past filter order");

	a_accept_to_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_LOAD && fire) |=> (pc_q == PC_MAC && tap_q == '0))
		else $error("request accepted but tap loop not started");

	a_result_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_RND_Y && fire) |=> (pc_q == PC_IDLE))
		else $error("sequencer did not return to idle after result");

	a_hold_on_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_RND_Y && out_busy) |=> (ctrl.op == OP_RND_Y))
		else $error("result step left while output register full");
`endif

endmodule

### src/iirdf2_dp.sv
// Datapath: two multiply-accumulate units, rounding and saturation, delay line
// and output register. Driven by the sequencer; depends on iirdf2_pkg.
`timescale 1ns / 1ps

module iirdf2_dp
	import iirdf2_pkg::*;
#(
	parameter int ORDER = 3,
	parameter int TAP_W = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_ctrl_t         dp_ctrl,
	input  logic [TAP_W-1:0] tap,
	input  coef_t            ff_coef [NUM_FF],
	input  coef_t            fb_coef [NUM_FB],
	input  sample_t          sample_in,
	input  logic             out_stall,
	output logic             out_valid,
	output sample_t          sample_out
);

	state_t                 d_q [ORDER];
	acc_t                   w_acc_q;
	acc_t                   y_acc_q;
	state_t                 w_q;
	sample_t                sample_out_q;
	logic                   out_valid_q;
	logic [TAP_SEL_W-1:0]   fb_idx;
	logic [TAP_SEL_W-1:0]   ff_idx;
	coef_t                  ma_coef;
	coef_t                  mb_coef;
	state_t                 ma_data;
	state_t                 mb_data;
	prod_t                  prod_a;
	prod_t                  prod_b;
	rnd_t                   w_rnd;
	rnd_t                   y_rnd;
	state_t                 w_sat;
	sample_t                y_sat;

	function automatic rnd_t round_q(acc_t v);
		acc_t t;
		t = v + acc_t'(2 ** (FRAC_W - 1));
		return rnd_t'(t[ACC_W-1:FRAC_W]);
	endfunction

	assign fb_idx = TAP_SEL_W'(tap);
	assign ff_idx = TAP_SEL_W'(tap) + TAP_SEL_W'(1);

	assign ma_coef = fb_coef[fb_idx];
	assign ma_data = d_q[tap];
	assign mb_coef = (dp_ctrl.op == OP_MAC_B0) ? ff_coef[0] : ff_coef[ff_idx];
	assign mb_data = (dp_ctrl.op == OP_MAC_B0) ? w_q : d_q[tap];

	assign prod_a = prod_t'(ma_coef) * prod_t'(ma_data);
	assign prod_b = prod_t'(mb_coef) * prod_t'(mb_data);

	assign w_rnd = round_q(w_acc_q);
	assign y_rnd = round_q(y_acc_q);

	always_comb begin
		if ((&w_rnd[RND_W-1:STATE_W-1]) || !(|w_rnd[RND_W-1:STATE_W-1])) begin
			w_sat = w_rnd[STATE_W-1:0];
		end else if (w_rnd[RND_W-1]) begin
			w_sat = {1'b1, {(STATE_W-1){1'b0}}};
		end else begin
			w_sat = {1'b0, {(STATE_W-1){1'b1}}};
		end
	end

	always_comb begin
		if ((&y_rnd[RND_W-1:SAMPLE_W-1]) || !(|y_rnd[RND_W-1:SAMPLE_W-1])) begin
			y_sat = y_rnd[SAMPLE_W-1:0];
		end else if (y_rnd[RND_W-1]) begin
			y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (dp_ctrl.fire) begin
			case (dp_ctrl.op)
				OP_LOAD: begin
					w_acc_q <= acc_t'(sample_in) <<< FRAC_W;
					y_acc_q <= '0;
				end
				OP_MAC: begin
					w_acc_q <= w_acc_q - acc_t'(prod_a);
					y_acc_q <= y_acc_q + acc_t'(prod_b);
				end
				OP_RND_W: begin
					w_q <= w_sat;
				end
				OP_MAC_B0: begin
					y_acc_q <= y_acc_q + acc_t'(prod_b);
				end
				OP_RND_Y: begin
					sample_out_q <= y_sat;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ORDER; k++) begin
				d_q[k] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (dp_ctrl.op == OP_RND_Y && dp_ctrl.fire) begin
				for (int k = ORDER - 1; k > 0; k--) begin
					d_q[k] <= d_q[k-1];
				end
				d_q[0]      <= w_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

endmodule

### src/iir_direct_form_two.sv
// Direct form II IIR filter, order up to three. A new request is accepted only
// in the idle step, after the previous sample's result is registered. The
// control program runs one shared feedback/feedforward multiply-accumulate
// step per tap, then rounding of w, the b0 product and rounding of y, which
// waits while the output register is full. Reset clears the delay line, loads
// b0 = 1.0 with all other coefficients zero, and returns the sequencer to idle.
`timescale 1ns / 1ps

module iir_direct_form_two
	import iirdf2_pkg::*;
#(
	parameter int ORDER = 3
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  cfg_idx_t cfg_index,
	input  coef_t    cfg_data,
	input  logic     in_valid,
	output logic     in_stall,
	input  sample_t  sample_in,
	output logic     out_valid,
	input  logic     out_stall,
	output sample_t  sample_out
);

	localparam int TAP_W = (ORDER > 1) ? $clog2(ORDER) : 1;

	coef_t            ff_coef_q [NUM_FF];
	coef_t            fb_coef_q [NUM_FB];
	dp_ctrl_t         dp_ctrl;
	logic [TAP_W-1:0] tap;
	logic             out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_coef_q[0] <= COEF_B0_RESET;
			ff_coef_q[1] <= '0;
			ff_coef_q[2] <= '0;
			ff_coef_q[3] <= '0;
			fb_coef_q[0] <= '0;
			fb_coef_q[1] <= '0;
			fb_coef_q[2] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FF_COEF_0: ff_coef_q[0] <= cfg_data;
				REG_FF_COEF_1: ff_coef_q[1] <= cfg_data;
				REG_FF_COEF_2: ff_coef_q[2] <= cfg_data;
				REG_FF_COEF_3: ff_coef_q[3] <= cfg_data;
				REG_FB_COEF_1: fb_coef_q[0] <= cfg_data;
				REG_FB_COEF_2: fb_coef_q[1] <= cfg_data;
				REG_FB_COEF_3: fb_coef_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign out_busy = out_valid && out_stall;
	assign in_stall = (dp_ctrl.op != OP_LOAD);

	iirdf2_seq #(
		.ORDER(ORDER),
		.TAP_W(TAP_W)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.out_busy(out_busy),
		.dp_ctrl (dp_ctrl),
		.tap     (tap)
	);

	iirdf2_dp #(
		.ORDER(ORDER),
		.TAP_W(TAP_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dp_ctrl   (dp_ctrl),
		.tap       (tap),
		.ff_coef   (ff_coef_q),
		.fb_coef   (fb_coef_q),
		.sample_in (sample_in),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.sample_out(sample_out)
	);

endmodule

### tb/iir_direct_form_two_test.sv
// Self-checking testbench for iir_direct_form_two: drives samples through the
// valid/stall request channel, predicts each filtered sample and compares.
// Depends on iirdf2_pkg and the iir_direct_form_two RTL only.
`timescale 1ns / 1ps

module iir_direct_form_two_test;
	import iirdf2_pkg::*;

	localparam int       ORDER      = 3;
	localparam int       LIMIT      = 400000;
	localparam int       PHASES     = 8;
	localparam int       PHASE_REQS = 205;
	localparam cfg_idx_t REG_SPARE  = cfg_idx_t'(7);
	localparam coef_t    COEF_MAX   = coef_t'(131071);
	localparam coef_t    COEF_MIN   = coef_t'(-131072);
	localparam longint   W_HI       = (64'sd1 <<< (STATE_W - 1)) - 1;
	localparam longint   W_LO       = -(64'sd1 <<< (STATE_W - 1));
	localparam longint   Y_HI       = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
	localparam longint   Y_LO       = -(64'sd1 <<< (SAMPLE_W - 1));

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cfg_we = 1'b0;
	cfg_idx_t cfg_index = '0;
	coef_t    cfg_data = '0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	sample_t  sample_in = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	sample_t  sample_out;

	sample_t     pending_samples[$];
	sample_t     expected_samples[$];
	coef_t       ff_coef[NUM_FF];
	coef_t       fb_coef[NUM_FB];
	state_t      taps[MAX_TAPS];
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int          errors = 0;
	int          cycles = 0;

	iir_direct_form_two #(.ORDER(ORDER)) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint round_sat(longint v, longint lo, longint hi);
		longint r;
		r = (v + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
		if (r < lo)
			return lo;
		if (r > hi)
			return hi;
		return r;
	endfunction

	function automatic sample_t filter_sample(sample_t x);
		longint w_acc, y_acc, w, y;
		w_acc = longint'(x) <<< FRAC_W;
		y_acc = 0;
		for (int k = 0; k < ORDER; k++) begin
			w_acc -= longint'(fb_coef[k]) * longint'(taps[k]);
			y_acc += longint'(ff_coef[k + 1]) * longint'(taps[k]);
		end
		w = round_sat(w_acc, W_LO, W_HI);
		y_acc += longint'(ff_coef[0]) * w;
		y = round_sat(y_acc, Y_LO, Y_HI);
		for (int k = ORDER - 1; k > 0; k--)
			taps[k] = taps[k - 1];
		taps[0] = state_t'(w);
		return sample_t'(y);
	endfunction

	function automatic sample_t pick_sample();
		int unsigned style;
		style = $urandom_range(9);
		if (style <= 4)
			return sample_t'($urandom);
		if (style <= 7)
			return sample_t'(int'($urandom_range(1024)) - 512);
		if (style == 8)
			return $urandom_range(1) ? sample_t'(Y_HI) : sample_t'(Y_LO);
		return (pending_samples.size() != 0) ? pending_samples[$] : sample_t'(0);
	endfunction

	function automatic coef_t pick_coef(int unsigned shape);
		case (shape)
			0: return coef_t'($urandom);
			1: return coef_t'(int'($urandom_range(8192)) - 4096);
			2: return $urandom_range(1) ? COEF_MAX : COEF_MIN;
			default: return ($urandom_range(3) == 0) ? coef_t'(0) :
				coef_t'(int'($urandom_range(32768)) - 16384);
		endcase
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	task automatic write_coef(cfg_idx_t idx, coef_t data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx <= REG_FF_COEF_3)
			ff_coef[TAP_SEL_W'(idx)] = data;
		else if (idx <= REG_FB_COEF_3)
			fb_coef[TAP_SEL_W'(idx - REG_FB_COEF_1)] = data;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || expected_samples.size() != 0 || in_valid);
		repeat (ORDER + 4) @(negedge clk);
	endtask

	// driver: offer pending samples, predict on each accepted request
	always @(posedge clk) begin : driver_b
		if (in_valid && !in_stall)
			expected_samples.push_back(filter_sample(sample_in));
		if (!in_valid || !in_stall) begin
			if (arst_n && pending_samples.size() != 0 &&
			    $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				sample_in <= pending_samples.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor_b
		sample_t want;
		if (out_valid && !out_stall) begin
			if (expected_samples.size() == 0) begin
				report_mismatch($sformatf("unexpected sample_out %0d", sample_out));
			end else begin
				want = expected_samples.pop_front();
				if (sample_out !== want)
					report_mismatch($sformatf("sample_out %0d, want %0d",
						sample_out, want));
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin : watchdog_b
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("iir_direct_form_two_test: errors");
			$finish;
		end
	end

	initial begin : stimulus_b
		int unsigned mode;
		for (int k = 0; k < NUM_FF; k++)
			ff_coef[k] = coef_t'(0);
		for (int k = 0; k < NUM_FB; k++)
			fb_coef[k] = coef_t'(0);
		for (int k = 0; k < MAX_TAPS; k++)
			taps[k] = state_t'(0);
		ff_coef[0] = COEF_B0_RESET;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// identity filter after reset: rounding and extremes pass through
		pending_samples = '{sample_t'(0), sample_t'(1), sample_t'(-1), sample_t'(Y_HI),
			sample_t'(Y_LO), sample_t'(Y_HI), sample_t'(Y_LO), sample_t'(12345)};
		wait_idle();

		// extreme coefficients drive w and y into saturation
		write_coef(REG_FF_COEF_0, COEF_MAX);
		write_coef(REG_FF_COEF_1, COEF_MIN);
		write_coef(REG_FF_COEF_2, COEF_MAX);
		write_coef(REG_FF_COEF_3, COEF_MIN);
		write_coef(REG_FB_COEF_1, COEF_MIN);
		write_coef(REG_FB_COEF_2, COEF_MAX);
		write_coef(REG_FB_COEF_3, COEF_MIN);
		write_coef(REG_SPARE, coef_t'(0));
		pending_samples = '{sample_t'(Y_HI), sample_t'(Y_HI), sample_t'(Y_HI),
			sample_t'(Y_HI), sample_t'(Y_LO), sample_t'(Y_LO), sample_t'(Y_LO),
			sample_t'(Y_LO), sample_t'(0), sample_t'(1)};
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			mode = $urandom_range(3);
			for (int r = REG_FF_COEF_0; r <= REG_FB_COEF_3; r++)
				write_coef(cfg_idx_t'(r), pick_coef(mode));
			write_coef(REG_SPARE, coef_t'($urandom));
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			for (int n = 0; n < PHASE_REQS; n++)
				pending_samples.push_back(pick_sample());
			wait_idle();
		end

		recv_stall_pct = 0;
		repeat (ORDER + 8) @(posedge clk);
		if (errors == 0)
			$display("iir_direct_form_two_test: clean");
		else
			$display("iir_direct_form_two_test: errors");
		$finish;
	end

endmodule

### sim.f
src/iirdf2_pkg.sv
src/iirdf2_seq.sv
src/iirdf2_dp.sv
src/iir_direct_form_two.sv
tb/iir_direct_form_two_test.sv
